// File: rtl/pidc_pkg.sv
// Shared types, widths and codes for the clamped-integral PID controller.
`default_nettype none
package pidc_pkg;

  localparam int ERR_W          = 16;
  localparam int TICK_W         = 16;
  localparam int GAIN_W         = 16;
  localparam int INTEG_W        = 24;
  localparam int DRIVE_W        = 32;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int FRAC_BITS_DEF  = 8;

  // Shared multiplier: gain times the widest integer operand (sum plus error).
  localparam int MUL_B_W  = INTEG_W + 1;
  localparam int MUL_P_W  = GAIN_W + MUL_B_W;
  // Derivative: gain times error difference, magnitude fed to the divider.
  localparam int DIFF_W   = ERR_W + 1;
  localparam int DIV_N_W  = GAIN_W + DIFF_W;
  localparam int DIV_C_W  = $clog2(DIV_N_W);
  // Accumulator holds the exact sum of the three terms.
  localparam int ACC_W    = MUL_P_W + 2;

  localparam logic signed [INTEG_W-1:0] UPPER_RST = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] LOWER_RST = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INTEG_UPPER = 3'd3,
    CFG_INTEG_LOWER = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] error_value;
    logic [TICK_W-1:0]       elapsed_ticks;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      deriv_skipped;
    logic                      integ_clamped;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/pid_controller_clamped_integral_top.sv
// Top level of the PID controller with clamped integral sum.
// Each sample word gives an error and the ticks since the previous sample; one result
// word follows with the saturated sum of the proportional, integral and derivative terms.
// A sequencer runs the three gain products one after another through a single shared
// multiplier, then divides the derivative product by the ticks in a serial divider that
// yields one quotient bit per cycle. No new sample is taken while one is in progress;
// the divide is bypassed when the derivative is skipped. The next sample is taken once
// the result is loaded into the output register, even if that result still waits to be
// taken downstream.
// Configuration must be written while no sample is in progress; this is not enforced.
`default_nettype none
module pid_controller_clamped_integral_top import pidc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic signed [GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic signed [INTEG_W-1:0] integ_upper, integ_lower;

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic                      have_previous;

  logic signed [ERR_W-1:0]   err;
  logic [TICK_W-1:0]         ticks;
  logic signed [MUL_B_W-1:0] sum_new;
  logic signed [DIFF_W-1:0]  diff;
  logic                      skipped;
  logic                      clamped;
  logic                      dneg;
  logic signed [ACC_W-1:0]   acc;

  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [MUL_P_W-1:0]        prod_mag;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_N_W-1:0]        quotient;

  logic                      accept;
  logic                      out_free;
  logic signed [MUL_B_W-1:0] clamp_hi;
  logic signed [MUL_B_W-1:0] clamp_val;
  logic                      clamp_hit;
  logic signed [ACC_W-1:0]   shifted;
  logic                      pos_ovf, neg_ovf;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  pidc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_mag = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[DIV_N_W-1:0]),
    .divisor  (ticks),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    mul_a        = prop_gain;
    mul_b        = MUL_B_W'(err);
    div_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = ST_PROP;
        end
      end
      ST_PROP: begin
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        mul_a      = integ_gain;
        mul_b      = sum_new;
        state_next = ST_DERIV;
      end
      ST_DERIV: begin
        mul_a      = deriv_gain;
        mul_b      = MUL_B_W'(diff);
        state_next = ST_DSTART;
      end
      ST_DSTART: begin
        if (skipped) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_upper <= UPPER_RST;
      integ_lower <= LOWER_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:   prop_gain   <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain  <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:  deriv_gain  <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_UPPER: integ_upper <= cfg_data[INTEG_W-1:0];
        CFG_INTEG_LOWER: integ_lower <= cfg_data[INTEG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Upper bound first, then lower, so crossed bounds settle on the lower one
  always_comb begin
    clamp_hi  = (sum_new > MUL_B_W'(integ_upper)) ? MUL_B_W'(integ_upper) : sum_new;
    clamp_val = (clamp_hi < MUL_B_W'(integ_lower)) ? MUL_B_W'(integ_lower) : clamp_hi;
    clamp_hit = (sum_new > MUL_B_W'(integ_upper)) || (clamp_hi < MUL_B_W'(integ_lower));
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      have_previous  <= 1'b0;
    end else begin
      if (accept) begin
        previous_error <= sample.error_value;
        have_previous  <= 1'b1;
      end
      if (state == ST_PROP) begin
        integral_sum <= clamp_val[INTEG_W-1:0];
      end
    end
  end

  // Per-sample datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      err     <= sample.error_value;
      ticks   <= sample.elapsed_ticks;
      sum_new <= MUL_B_W'(integral_sum) + MUL_B_W'(sample.error_value);
      diff    <= DIFF_W'(sample.error_value) - DIFF_W'(previous_error);
      skipped <= !have_previous || (sample.elapsed_ticks == '0);
    end
    case (state)
      ST_PROP: begin
        clamped <= clamp_hit;
      end
      ST_INTEG: begin
        acc <= ACC_W'(prod);
      end
      ST_DERIV: begin
        acc <= acc + ACC_W'(prod);
      end
      ST_DSTART: begin
        dneg <= prod[MUL_P_W-1];
      end
      ST_DIV: begin
        // quotient truncates toward zero; restore the sign here
        if (div_done) begin
          acc <= dneg ? acc - $signed(ACC_W'(quotient)) : acc + $signed(ACC_W'(quotient));
        end
      end
      default: begin
      end
    endcase
  end

  // Floor shift to integer units, then saturate to the drive width
  always_comb begin
    shifted   = acc >>> GAIN_FRAC_BITS;
    pos_ovf   = !shifted[ACC_W-1] && (|shifted[ACC_W-2:DRIVE_W-1]);
    neg_ovf   = shifted[ACC_W-1] && !(&shifted[ACC_W-2:DRIVE_W-1]);
    drive_sat = shifted[DRIVE_W-1:0];
    if (pos_ovf) begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      result.drive_value   <= drive_sat;
      result.deriv_skipped <= skipped;
      result.integ_clamped <= clamped;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pidc_mul.sv
// Shared signed gain multiplier with a registered product.
`default_nettype none
module pidc_mul import pidc_pkg::*; (
  input  logic                      clk,
  input  logic signed [GAIN_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// File: rtl/pidc_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module pidc_div import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [TICK_W-1:0]  divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_N_W-1:0] quo;
  logic [TICK_W-1:0]  rem;
  logic [TICK_W-1:0]  dvs;
  logic [DIV_C_W-1:0] count;
  logic               running;
  logic [TICK_W:0]    trial;
  logic [TICK_W:0]    trial_sub;
  logic               fits;

  always_comb begin
    trial     = {rem, quo[DIV_N_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= DIV_C_W'(DIV_N_W - 1);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      // shift in next dividend bit, subtract when it fits
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// File: tb/pid_controller_clamped_integral_top_tb.sv
// Self-checking testbench for the clamped-integral PID controller top level.
module pid_controller_clamped_integral_top_tb;
  import pidc_pkg::*;

  localparam int RUN_LIMIT     = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 116;
  localparam int DRIFT_ITEMS   = 270;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_INTEG_LOWER + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [TICK_W-1:0]        TICK_MAX = '1;

  localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

  typedef enum int {
    ERR_UNIFORM,
    ERR_SMALL,
    ERR_RISING,
    ERR_FALLING
  } err_style_t;

  class drive_predictor;
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic signed [INTEG_W-1:0] upper, lower, integ_acc;
    logic signed [ERR_W-1:0]   last_err;
    bit                        seen_sample;
    result_t                   pending_drive[$];
    int                        failures;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      upper = UPPER_RST;
      lower = LOWER_RST;
      integ_acc = '0;
      last_err = '0;
      seen_sample = 1'b0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_PROP_GAIN:   kp = data[GAIN_W-1:0];
        CFG_INTEG_GAIN:  ki = data[GAIN_W-1:0];
        CFG_DERIV_GAIN:  kd = data[GAIN_W-1:0];
        CFG_INTEG_UPPER: upper = data[INTEG_W-1:0];
        CFG_INTEG_LOWER: lower = data[INTEG_W-1:0];
        default: ;
      endcase
    endfunction

    // Products stay far below the longint range at these widths.
    function void take_sample(sample_t s);
      longint  err, sum, prop, integ, deriv, total, scaled;
      result_t want;
      err = longint'($signed(s.error_value));
      prop = longint'(kp) * err;
      sum = longint'(integ_acc) + err;
      integ = longint'(ki) * sum;
      want.integ_clamped = 1'b0;
      // upper test first, so crossed bounds leave the sum at the lower one
      if (sum > longint'(upper)) begin
        sum = longint'(upper);
        want.integ_clamped = 1'b1;
      end
      if (sum < longint'(lower)) begin
        sum = longint'(lower);
        want.integ_clamped = 1'b1;
      end
      integ_acc = sum[INTEG_W-1:0];
      want.deriv_skipped = !seen_sample || s.elapsed_ticks == '0;
      deriv = 0;
      if (!want.deriv_skipped)
        deriv = longint'(kd) * (err - longint'(last_err)) / longint'(s.elapsed_ticks);
      last_err = s.error_value;
      seen_sample = 1'b1;
      total = prop + integ + deriv;
      // drop the fraction bits, rounding toward minus infinity
      scaled = total >>> FRAC_BITS_DEF;
      if (scaled > DRIVE_MAX) scaled = DRIVE_MAX;
      if (scaled < DRIVE_MIN) scaled = DRIVE_MIN;
      want.drive_value = scaled[DRIVE_W-1:0];
      pending_drive.push_back(want);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_drive.size() == 0) begin
        $display("%0t: result word with nothing pending: drive %0d skipped %0b clamped %0b",
                 $time, got.drive_value, got.deriv_skipped, got.integ_clamped);
        failures++;
        return;
      end
      want = pending_drive.pop_front();
      if (got.drive_value !== want.drive_value) begin
        $display("%0t: drive_value expected %0d actual %0d",
                 $time, want.drive_value, got.drive_value);
        failures++;
      end
      if (got.deriv_skipped !== want.deriv_skipped) begin
        $display("%0t: deriv_skipped expected %0b actual %0b",
                 $time, want.deriv_skipped, got.deriv_skipped);
        failures++;
      end
      if (got.integ_clamped !== want.integ_clamped) begin
        $display("%0t: integ_clamped expected %0b actual %0b",
                 $time, want.integ_clamped, got.integ_clamped);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b1;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  bit             steady = 1'b0;
  int             long_hold = 0;
  int unsigned    cycle_count = 0;
  drive_predictor drive_calc = new();

  pid_controller_clamped_integral_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("pid_controller_clamped_integral_top verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic signed [ERR_W-1:0] draw_error(input err_style_t style);
    logic signed [ERR_W-1:0] v;
    v = ERR_W'($urandom);
    if ($urandom_range(0, 15) == 0)
      v = $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
    else if ($urandom_range(0, 3) != 0)
      case (style)
        ERR_SMALL:   v = ERR_W'(int'($urandom_range(0, 127)) - 64);
        ERR_RISING:  v = ERR_MAX - ERR_W'($urandom_range(0, 2047));
        ERR_FALLING: v = ERR_MIN + ERR_W'($urandom_range(0, 2047));
        default: ;
      endcase
    return v;
  endfunction

  function automatic logic [TICK_W-1:0] draw_ticks();
    logic [TICK_W-1:0] t;
    case ($urandom_range(0, 7))
      0: t = '0;
      1: t = TICK_W'(1);
      2: t = TICK_MAX;
      3: t = TICK_W'($urandom_range(1, 8));
      default: t = TICK_W'($urandom);
    endcase
    return t;
  endfunction

  function automatic logic signed [GAIN_W-1:0] draw_gain();
    logic signed [GAIN_W-1:0] g;
    case ($urandom_range(0, 5))
      0: g = GAIN_MIN;
      1: g = GAIN_MAX;
      2: g = '0;
      3: g = GAIN_W'(int'($urandom_range(0, 1024)) - 512);
      default: g = GAIN_W'($urandom);
    endcase
    return g;
  endfunction

  task automatic send_sample(input logic signed [ERR_W-1:0] err,
                             input logic [TICK_W-1:0] ticks);
    int      gap;
    sample_t word;
    gap = draw_gap();
    word.error_value = err;
    word.elapsed_ticks = ticks;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= word;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    drive_calc.take_sample(word);
  endtask

  // Drop valid and wait until every pending result word has come back.
  task automatic finish_phase();
    sample_valid <= 1'b0;
    while (drive_calc.pending_drive.size() != 0) @(posedge clk);
  endtask

  // Write all five registers back to back, then one write to an unused index.
  task automatic load_settings(input logic signed [GAIN_W-1:0] kp, ki, kd,
                               input logic signed [INTEG_W-1:0] upper, lower);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_W-1:0]     data [6];
    idx[0] = CFG_PROP_GAIN;
    idx[1] = CFG_INTEG_GAIN;
    idx[2] = CFG_DERIV_GAIN;
    idx[3] = CFG_INTEG_UPPER;
    idx[4] = CFG_INTEG_LOWER;
    idx[5] = CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI));
    for (int k = 0; k < 6; k++) data[k] = CFG_W'($urandom);
    data[0][GAIN_W-1:0] = kp;
    data[1][GAIN_W-1:0] = ki;
    data[2][GAIN_W-1:0] = kd;
    data[3] = upper;
    data[4] = lower;
    for (int k = 0; k < 6; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= data[k];
      drive_calc.write_register(idx[k], data[k]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_random_phase(input int count, input bit widest_bounds);
    logic signed [INTEG_W-1:0] upper, lower;
    err_style_t                style;
    style = err_style_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        upper = UPPER_RST;
        lower = LOWER_RST;
      end
      1: begin
        upper = INTEG_W'(-int'($urandom_range(0, 3000)));
        lower = INTEG_W'($urandom_range(0, 3000));
      end
      2: begin
        upper = INTEG_W'($urandom_range(0, 5000));
        lower = INTEG_W'(-int'($urandom_range(0, 5000)));
      end
      default: begin
        upper = INTEG_W'($urandom);
        lower = INTEG_W'($urandom);
      end
    endcase
    if (widest_bounds) begin
      upper = UPPER_RST;
      lower = LOWER_RST;
    end
    load_settings(draw_gain(), draw_gain(), draw_gain(), upper, lower);
    for (int k = 0; k < count; k++) send_sample(draw_error(style), draw_ticks());
    finish_phase();
  endtask

  initial begin : receiver
    int hold;
    wait (!rst);
    forever begin
      hold = draw_gap();
      if (long_hold != 0) begin
        hold = long_hold;
        long_hold = 0;
      end
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      drive_calc.match_result(result);
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero gains, widest bounds; push the sum into the upper bound
    send_sample(ERR_MAX, 16'd9);
    for (int k = 0; k < DRIFT_ITEMS; k++) send_sample(draw_error(ERR_RISING), draw_ticks());
    finish_phase();

    load_settings(GAIN_MAX, GAIN_MIN, GAIN_MIN, 24'sd40000, -24'sd40000);
    send_sample(ERR_MAX, 16'd1);
    send_sample(ERR_MIN, 16'd1);
    send_sample(ERR_MIN, 16'd0);
    send_sample(ERR_MAX, TICK_MAX);
    send_sample(16'sd0, 16'd0);
    send_sample(16'sd1, 16'd3);
    send_sample(-16'sd1, 16'd7);
    send_sample(ERR_MIN, TICK_MAX);
    send_sample(ERR_MAX, 16'd2);
    repeat (3) send_sample(ERR_MAX, 16'd1);
    repeat (4) send_sample(ERR_MIN, 16'd1);
    finish_phase();

    // crossed bounds: the sum must end at the lower bound
    load_settings(GAIN_MIN, GAIN_MAX, GAIN_MAX, -24'sd50, 24'sd50);
    send_sample(16'sd100, 16'd4);
    send_sample(-16'sd100, 16'd4);
    send_sample(16'sd0, 16'd0);
    finish_phase();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph == 4);
      if (ph == 2) long_hold = LONG_HOLD;
      run_random_phase(PHASE_ITEMS, ph == 0);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_calc.failures == 0 && drive_calc.pending_drive.size() == 0)
      $display("pid_controller_clamped_integral_top verification clean");
    else
      $display("pid_controller_clamped_integral_top verification failed");
    $finish;
  end

endmodule
